>>> rtl/salc_pkg.sv
// Shared types and constants of the set-associative LRU tag store.
package salc_pkg;

    localparam int TAG_W   = 30;
    localparam int AGE_W   = 6;
    localparam int IDX_W   = 9;
    localparam int OUT_W   = 6;
    localparam int CNT_W   = 32;
    localparam int LOG_W   = 4;
    localparam int CFG_AW  = 4;
    localparam int CFG_DW  = 32;
    localparam int IN_DW   = 32;
    localparam int OUT_DW  = 80;

    localparam int MAX_LINES_DEF = 64;
    localparam int ADDR_BITS_DEF = 32;

    localparam logic [AGE_W-1:0] AGE_MAX = {AGE_W{1'b1}};

    localparam logic [8:0] CB_RESET = 9'd64;
    localparam logic [2:0] BW_RESET = 3'd1;
    localparam logic [4:0] WY_RESET = 5'd1;

    typedef enum logic [1:0] {
        REG_CACHE_BYTES = 2'd0,
        REG_BLOCK_WORDS = 2'd1,
        REG_WAYS        = 2'd2,
        REG_FULLY_ASSOC = 2'd3
    } reg_idx_t;

    // Set window and tag of the access in flight
    typedef struct packed {
        logic [IDX_W-1:0] base;
        logic [IDX_W-1:0] lim;
        logic [TAG_W-1:0] tag;
    } lk_t;

    // Scan token handed from cell to cell
    typedef struct packed {
        logic             hit;
        logic [IDX_W-1:0] hit_line;
        logic [AGE_W-1:0] hit_age;
        logic             inv;
        logic [IDX_W-1:0] inv_line;
        logic [AGE_W-1:0] best_age;
        logic [IDX_W-1:0] best_line;
    } tok_t;

    // Update broadcast after the scan
    typedef struct packed {
        logic             en;
        logic             hit;
        logic [IDX_W-1:0] line;
        logic [AGE_W-1:0] age_a;
    } upd_t;

endpackage

>>> rtl/set_assoc_cache_lru_lookup_top.sv
// Top level of the set-associative tag store with LRU replacement.
//
//  channel  dir  fields
//  s_       in   byte_address
//  m_       out  hit, set_index, way_used, evicted, hit_total, miss_total
//  apb      in   cache_bytes, block_words, ways, fully_associative
//
// For each item the scan token walks the row of line cells one cell per
// cycle, then the LRU update is applied in the ST_UPD state.
// A new beat is taken only while no scan runs; a finished result may wait
// on m_tready while the next beat is taken, and the update holds until the
// output register is free. Reset clears all valid bits, ages and totals;
// any register write invalidates every line.
module set_assoc_cache_lru_lookup_top #(
    parameter int MAX_LINES = salc_pkg::MAX_LINES_DEF,
    parameter int ADDR_BITS = salc_pkg::ADDR_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [salc_pkg::IN_DW-1:0]    s_tdata,   // byte_address[31:0]
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // hit[0], set_index[6:1], way_used[12:7], evicted[13],
    // hit_total[45:14], miss_total[77:46], zero[79:78]
    output logic [salc_pkg::OUT_DW-1:0]   m_tdata,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [salc_pkg::CFG_AW-1:0]   paddr,
    input  logic [salc_pkg::CFG_DW-1:0]   pwdata,
    output logic [salc_pkg::CFG_DW-1:0]   prdata,
    output logic                          pready
);

    localparam int LG_MAX = $clog2(MAX_LINES + 1) - 1;
    localparam int IW     = salc_pkg::IDX_W;
    localparam int LW     = salc_pkg::LOG_W;

    typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_UPD} state_t;

    state_t                     state_reg;
    logic [8:0]                 cb_reg;
    logic [2:0]                 bw_reg;
    logic [4:0]                 wy_reg;
    logic                       fa_reg;
    salc_pkg::lk_t              lk_reg;
    logic [IW-1:0]              set_reg;
    logic                       start_reg;
    salc_pkg::tok_t             fin_reg;
    logic                       m_tvalid_reg;
    logic [salc_pkg::OUT_DW-1:0] m_tdata_reg;
    logic [salc_pkg::CNT_W-1:0] hits_reg;
    logic [salc_pkg::CNT_W-1:0] miss_reg;

    logic                       cfg_wr;
    logic                       s_acc;
    logic                       out_free;
    logic                       fire;
    salc_pkg::upd_t             up;
    salc_pkg::tok_t             tok_init;
    logic                       act_w [0:MAX_LINES];
    salc_pkg::tok_t             tok_w [0:MAX_LINES];

    logic [LW-1:0]              lg_cb;
    logic [LW-1:0]              lg_bw;
    logic [LW-1:0]              lg_lines;
    logic [LW-1:0]              lg_nw;
    logic [LW-1:0]              lg_sets;
    logic [31:0]                addr;
    logic [31:0]                block;
    logic [31:0]                tag_full;
    logic [IW-1:0]              set_mask;
    logic [IW-1:0]              set_c;
    logic [IW-1:0]              base_c;
    logic [IW-1:0]              sel_line;
    logic [IW-1:0]              way_c;
    logic                       evict_c;
    logic [salc_pkg::CNT_W-1:0] hits_next;
    logic [salc_pkg::CNT_W-1:0] miss_next;

    function automatic logic [LW-1:0] flog2(input logic [8:0] v);
        logic [LW-1:0] r;
        r = '0;
        for (int b = 0; b < 9; b++) begin
            if (v[b]) r = LW'(b);
        end
        return r;
    endfunction

    // Geometry from the registers
    always_comb begin
        if (cb_reg < 9'd16) lg_cb = LW'(4);
        else                lg_cb = flog2(cb_reg);
        if (bw_reg >= 3'd4)      lg_bw = LW'(2);
        else if (bw_reg >= 3'd2) lg_bw = LW'(1);
        else                     lg_bw = LW'(0);
        lg_lines = lg_cb - LW'(2) - lg_bw;
        if (lg_lines > LW'(LG_MAX)) lg_lines = LW'(LG_MAX);
        lg_nw = flog2({4'd0, wy_reg});
        if (lg_nw > lg_lines || fa_reg) lg_nw = lg_lines;
        lg_sets = lg_lines - lg_nw;
        addr     = 32'(s_tdata[ADDR_BITS-1:0]);
        block    = (addr >> 2) >> lg_bw;
        tag_full = block >> lg_sets;
        set_mask = IW'((1 << lg_sets) - 1);
        set_c    = block[IW-1:0] & set_mask;
        base_c   = set_c << lg_nw;
    end

    assign cfg_wr   = psel && penable && pwrite && pready;
    assign s_tready = (state_reg == ST_IDLE);
    assign s_acc    = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign fire     = (state_reg == ST_UPD) && out_free;

    always_comb begin
        tok_init           = '0;
        tok_init.best_line = lk_reg.base;
    end

    assign act_w[0] = start_reg;
    assign tok_w[0] = tok_init;

    genvar g;
    generate
        for (g = 0; g < MAX_LINES; g++) begin : g_cell
            salc_cell #(.IDX(g)) u_cell (
                .aclk    (aclk),
                .aresetn (aresetn),
                .flush   (cfg_wr),
                .lk      (lk_reg),
                .up      (up),
                .in_act  (act_w[g]),
                .in_tok  (tok_w[g]),
                .out_act (act_w[g+1]),
                .out_tok (tok_w[g+1])
            );
        end
    endgenerate

    always_comb begin
        if (fin_reg.hit)      sel_line = fin_reg.hit_line;
        else if (fin_reg.inv) sel_line = fin_reg.inv_line;
        else                  sel_line = fin_reg.best_line;
        evict_c  = !fin_reg.hit && !fin_reg.inv;
        way_c    = sel_line - lk_reg.base;
        up.en    = fire;
        up.hit   = fin_reg.hit;
        up.line  = sel_line;
        up.age_a = fin_reg.hit_age;
        hits_next = hits_reg;
        miss_next = miss_reg;
        if (fin_reg.hit) begin
            if (hits_reg != '1) hits_next = hits_reg + 1'b1;
        end else begin
            if (miss_reg != '1) miss_next = miss_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            start_reg    <= 1'b0;
            m_tvalid_reg <= 1'b0;
            hits_reg     <= '0;
            miss_reg     <= '0;
            cb_reg       <= salc_pkg::CB_RESET;
            bw_reg       <= salc_pkg::BW_RESET;
            wy_reg       <= salc_pkg::WY_RESET;
            fa_reg       <= 1'b0;
        end else begin
            start_reg <= s_acc;
            if (cfg_wr) begin
                case (salc_pkg::reg_idx_t'(paddr[3:2]))
                    salc_pkg::REG_CACHE_BYTES: cb_reg <= pwdata[8:0];
                    salc_pkg::REG_BLOCK_WORDS: bw_reg <= pwdata[2:0];
                    salc_pkg::REG_WAYS:        wy_reg <= pwdata[4:0];
                    salc_pkg::REG_FULLY_ASSOC: fa_reg <= pwdata[0];
                    default: ;
                endcase
            end
            if (m_tvalid_reg && m_tready && !fire) m_tvalid_reg <= 1'b0;
            case (state_reg)
                ST_IDLE: begin
                    if (s_acc) state_reg <= ST_SCAN;
                end
                ST_SCAN: begin
                    if (act_w[MAX_LINES]) state_reg <= ST_UPD;
                end
                ST_UPD: begin
                    if (out_free) begin
                        m_tvalid_reg <= 1'b1;
                        hits_reg     <= hits_next;
                        miss_reg     <= miss_next;
                        state_reg    <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (s_acc) begin
            lk_reg.base <= base_c;
            lk_reg.lim  <= base_c + IW'(1 << lg_nw);
            lk_reg.tag  <= tag_full[salc_pkg::TAG_W-1:0];
            set_reg     <= set_c;
        end
        if (act_w[MAX_LINES]) begin
            fin_reg <= tok_w[MAX_LINES];
        end
        if (fire) begin
            m_tdata_reg <= {2'b00, miss_next, hits_next, evict_c,
                            way_c[salc_pkg::OUT_W-1:0], set_reg[salc_pkg::OUT_W-1:0],
                            fin_reg.hit};
        end
    end

    always_comb begin
        case (salc_pkg::reg_idx_t'(paddr[3:2]))
            salc_pkg::REG_CACHE_BYTES: prdata = 32'(cb_reg);
            salc_pkg::REG_BLOCK_WORDS: prdata = 32'(bw_reg);
            salc_pkg::REG_WAYS:        prdata = 32'(wy_reg);
            salc_pkg::REG_FULLY_ASSOC: prdata = 32'(fa_reg);
            default:                   prdata = '0;
        endcase
    end

    assign pready   = 1'b1;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    a_no_take_in_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> !s_tready)
        else $error("beat taken during scan");
    a_fire_gives_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        fire |=> m_tvalid)
        else $error("update without result beat");
    a_hit_no_evict: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[0] && m_tdata[13]))
        else $error("hit reported with eviction");
    a_scan_end_state: assert property (@(posedge aclk) disable iff (!aresetn)
        act_w[MAX_LINES] |-> (state_reg == ST_SCAN))
        else $error("scan token outside scan");

endmodule

>>> rtl/salc_cell.sv
// One cache line: valid, tag and LRU age, plus one stage of the scan chain.
module salc_cell #(
    parameter int IDX = 0
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             flush,
    input  salc_pkg::lk_t    lk,
    input  salc_pkg::upd_t   up,
    input  logic             in_act,
    input  salc_pkg::tok_t   in_tok,
    output logic             out_act,
    output salc_pkg::tok_t   out_tok
);

    localparam logic [salc_pkg::IDX_W-1:0] K = salc_pkg::IDX_W'(IDX);

    logic                         valid_reg;
    logic [salc_pkg::TAG_W-1:0]   tag_reg;
    logic [salc_pkg::AGE_W-1:0]   age_reg;
    logic                         act_reg;
    salc_pkg::tok_t               tok_reg;
    salc_pkg::tok_t               tok_next;
    logic                         in_set;
    logic                         match;
    logic [salc_pkg::AGE_W-1:0]   age_up;

    assign in_set = (K >= lk.base) && (K < lk.lim);
    assign match  = in_set && valid_reg && (tag_reg == lk.tag);
    assign age_up = (age_reg == salc_pkg::AGE_MAX) ? age_reg : age_reg + 1'b1;

    always_comb begin
        tok_next = in_tok;
        if (in_set) begin
            if (!in_tok.hit && match) begin
                tok_next.hit      = 1'b1;
                tok_next.hit_line = K;
                tok_next.hit_age  = age_reg;
            end
            if (!in_tok.inv && !valid_reg) begin
                tok_next.inv      = 1'b1;
                tok_next.inv_line = K;
            end
            // strict compare keeps the lowest way on ties
            if (age_reg > in_tok.best_age) begin
                tok_next.best_age  = age_reg;
                tok_next.best_line = K;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            age_reg   <= '0;
            act_reg   <= 1'b0;
        end else begin
            act_reg <= in_act;
            if (flush) begin
                valid_reg <= 1'b0;
                age_reg   <= '0;
            end else if (up.en && in_set) begin
                if (K == up.line) begin
                    age_reg <= '0;
                    if (!up.hit) begin
                        valid_reg <= 1'b1;
                    end
                end else if (valid_reg && (!up.hit || age_reg < up.age_a)) begin
                    age_reg <= age_up;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_act) begin
            tok_reg <= tok_next;
        end
        if (up.en && in_set && !up.hit && K == up.line) begin
            tag_reg <= lk.tag;
        end
    end

    assign out_act = act_reg;
    assign out_tok = tok_reg;

endmodule
